[rtl/core/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, register indexes, operand codes and the product schedule
// for the ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIST_WIDTH    = 31;
  localparam int NORM_WIDTH    = 16;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int WIDE          = 64;
  localparam int ACCW          = 128;

  // saturation bound +-(2^60-1)
  localparam logic signed [WIDE-1:0] WMAX = 64'sh0FFF_FFFF_FFFF_FFFF;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic   new_ray;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
  } rti_in_t;

  typedef struct packed {
    logic                         hit;
    logic [DIST_WIDTH-1:0]        distance;
    logic signed [NORM_WIDTH-1:0] normal_x;
    logic signed [NORM_WIDTH-1:0] normal_y;
    logic signed [NORM_WIDTH-1:0] normal_z;
  } rti_out_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_ORG_X    = 3'd0,
    REG_ORG_Y    = 3'd1,
    REG_ORG_Z    = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_MAX_DIST = 3'd6
  } rti_reg_t;

  // request to the divide / square root unit
  typedef struct packed {
    logic       start;
    logic       sqrt_mode;
    logic [5:0] count;
  } rti_ds_req_t;

  // operand selects for the shared multiplier
  typedef enum logic [4:0] {
    OP_DX, OP_DY, OP_DZ,
    OP_E1X, OP_E1Y, OP_E1Z,
    OP_E2X, OP_E2Y, OP_E2Z,
    OP_TX, OP_TY, OP_TZ,
    OP_PX, OP_PY, OP_PZ,
    OP_QX, OP_QY, OP_QZ,
    OP_NX, OP_NY, OP_NZ
  } rti_opnd_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_PX, DST_PY, DST_PZ, DST_QX, DST_QY, DST_QZ,
    DST_NX, DST_NY, DST_NZ, DST_DET, DST_UN, DST_VN, DST_TN
  } rti_dst_t;

  typedef struct packed {
    rti_opnd_t a;
    rti_opnd_t b;
    logic      neg;    // subtract this term
    logic      first;  // clear accumulator
    logic      last;   // saturate and write back
    logic      sq;     // exact square into the length sum
    rti_dst_t  dst;
  } rti_uop_t;

  localparam logic [5:0] STEP_TEST_END = 6'd23;
  localparam logic [5:0] STEP_NRM      = 6'd24;
  localparam logic [5:0] STEP_LAST     = 6'd32;

  // product schedule: p = d x e2, det, un, q = t x e1, vn, tn, n = e1 x e2, |n|^2
  function automatic rti_uop_t rti_ucode(input logic [5:0] step);
    rti_uop_t u;
    u = '{a: OP_DX, b: OP_DX, neg: 1'b0, first: 1'b0, last: 1'b0, sq: 1'b0,
          dst: DST_NONE};
    case (step)
      6'd0:  begin u.a = OP_DY;  u.b = OP_E2Z; u.first = 1'b1; end
      6'd1:  begin u.a = OP_DZ;  u.b = OP_E2Y; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_PX; end
      6'd2:  begin u.a = OP_DZ;  u.b = OP_E2X; u.first = 1'b1; end
      6'd3:  begin u.a = OP_DX;  u.b = OP_E2Z; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_PY; end
      6'd4:  begin u.a = OP_DX;  u.b = OP_E2Y; u.first = 1'b1; end
      6'd5:  begin u.a = OP_DY;  u.b = OP_E2X; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_PZ; end
      6'd6:  begin u.a = OP_E1X; u.b = OP_PX;  u.first = 1'b1; end
      6'd7:  begin u.a = OP_E1Y; u.b = OP_PY;  end
      6'd8:  begin u.a = OP_E1Z; u.b = OP_PZ;  u.last = 1'b1; u.dst = DST_DET; end
      6'd9:  begin u.a = OP_TX;  u.b = OP_PX;  u.first = 1'b1; end
      6'd10: begin u.a = OP_TY;  u.b = OP_PY;  end
      6'd11: begin u.a = OP_TZ;  u.b = OP_PZ;  u.last = 1'b1; u.dst = DST_UN; end
      6'd12: begin u.a = OP_TY;  u.b = OP_E1Z; u.first = 1'b1; end
      6'd13: begin u.a = OP_TZ;  u.b = OP_E1Y; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_QX; end
      6'd14: begin u.a = OP_TZ;  u.b = OP_E1X; u.first = 1'b1; end
      6'd15: begin u.a = OP_TX;  u.b = OP_E1Z; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_QY; end
      6'd16: begin u.a = OP_TX;  u.b = OP_E1Y; u.first = 1'b1; end
      6'd17: begin u.a = OP_TY;  u.b = OP_E1X; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_QZ; end
      6'd18: begin u.a = OP_DX;  u.b = OP_QX;  u.first = 1'b1; end
      6'd19: begin u.a = OP_DY;  u.b = OP_QY;  end
      6'd20: begin u.a = OP_DZ;  u.b = OP_QZ;  u.last = 1'b1; u.dst = DST_VN; end
      6'd21: begin u.a = OP_E2X; u.b = OP_QX;  u.first = 1'b1; end
      6'd22: begin u.a = OP_E2Y; u.b = OP_QY;  end
      6'd23: begin u.a = OP_E2Z; u.b = OP_QZ;  u.last = 1'b1; u.dst = DST_TN; end
      6'd24: begin u.a = OP_E1Y; u.b = OP_E2Z; u.first = 1'b1; end
      6'd25: begin u.a = OP_E1Z; u.b = OP_E2Y; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_NX; end
      6'd26: begin u.a = OP_E1Z; u.b = OP_E2X; u.first = 1'b1; end
      6'd27: begin u.a = OP_E1X; u.b = OP_E2Z; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_NY; end
      6'd28: begin u.a = OP_E1X; u.b = OP_E2Y; u.first = 1'b1; end
      6'd29: begin u.a = OP_E1Y; u.b = OP_E2X; u.neg = 1'b1; u.last = 1'b1; u.dst = DST_NZ; end
      6'd30: begin u.a = OP_NX;  u.b = OP_NX;  u.sq = 1'b1; u.first = 1'b1; end
      6'd31: begin u.a = OP_NY;  u.b = OP_NY;  u.sq = 1'b1; end
      6'd32: begin u.a = OP_NZ;  u.b = OP_NZ;  u.sq = 1'b1; end
      default: u.dst = DST_NONE;
    endcase
    return u;
  endfunction

  function automatic logic [WIDE-1:0] rti_mag(input logic signed [WIDE-1:0] x);
    return x[WIDE-1] ? (WIDE'(0) - x) : x;
  endfunction

endpackage

[rtl/core/rti_mul.sv]
// ----------------------------------------------------------------------------
// rti_mul
// Unsigned 64 x 64 multiplier, 16 multiplier bits per cycle.
// ----------------------------------------------------------------------------
module rti_mul
  import rti_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WIDE-1:0]     a,
  input  logic [WIDE-1:0]     b,
  output logic                done,
  output logic [ACCW-1:0]     prod
);

  logic [ACCW-1:0] acc_r;
  logic [WIDE-1:0] a_r, b_r;
  logic [1:0]      cnt_r;
  logic            busy_r, done_r;
  logic [WIDE+15:0] part;

  // one 64 x 16 partial product, high chunk first
  assign part = a_r * b_r[WIDE-1 -: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= {acc_r[ACCW-17:0], 16'd0} + ACCW'(part);
        b_r   <= {b_r[WIDE-17:0], 16'd0};
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/core/rti_divsqrt.sv]
// ----------------------------------------------------------------------------
// rti_divsqrt
// Restoring divider and integer square root sharing one compare/subtract,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module rti_divsqrt
  import rti_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  rti_ds_req_t     req,
  input  logic [ACCW-1:0] num,     // dividend or radicand
  input  logic [ACCW-1:0] den_sh,  // divisor aligned to the top quotient bit
  output logic            done,
  output logic [WIDE-1:0] res
);

  logic [ACCW-1:0] rem_r, sh_r, res_r;
  logic [5:0]      cnt_r;
  logic            busy_r, mode_r, done_r;
  logic [ACCW-1:0] cand;
  logic            ge;

  // shared compare against the trial value
  assign cand = mode_r ? (res_r | sh_r) : sh_r;
  assign ge   = (rem_r >= cand);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        mode_r <= req.sqrt_mode;
        cnt_r  <= req.count;
        rem_r  <= num;
        res_r  <= '0;
        sh_r   <= req.sqrt_mode ? (ACCW'(1) << 122) : den_sh;
      end else if (busy_r) begin
        if (ge) rem_r <= rem_r - cand;
        if (mode_r) begin
          res_r <= ge ? ((res_r >> 1) | sh_r) : (res_r >> 1);
          sh_r  <= sh_r >> 2;
        end else begin
          res_r <= {res_r[ACCW-2:0], ge};
          sh_r  <= sh_r >> 1;
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r[WIDE-1:0];

endmodule

[rtl/core/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test in signed fixed point, one shared
// multiplier and one shared divide/square-root unit under a sequencer.
// ----------------------------------------------------------------------------
// Flow: a small det or u, v or t out of range ends the test early; a miss after
//   the t divide ends it there; a hit goes on through the normal products, the
//   square root and one divide per normal component (skipped for a zero-length
//   normal), plus any out_stall wait.
// Throughput: one triangle at a time; in_stall is high from acceptance until
//   the word is loaded into the output register, the next word in the cycle after.
// Reset: synchronous; ray registers go to origin 0, direction +z, maximum
//   distance limits, and the closest distance to all ones.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rti_in_t             in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rti_out_t            out_word,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam logic [WIDE-1:0] EPS = WIDE'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [ACCW-1:0] RND = (ACCW'(1) << FRAC_BITS) - ACCW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_MWAIT, S_POST, S_ACC, S_FOLD, S_TEST, S_TWAIT,
    S_SQRT, S_SQWAIT, S_NDIV, S_NWAIT, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  coord_t org_x_r, org_y_r, org_z_r, dir_x_r, dir_y_r, dir_z_r;
  logic [DIST_WIDTH-1:0] maxd_r, closest_r;

  // working registers
  logic signed [WIDE-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [WIDE-1:0] tx_r, ty_r, tz_r;
  logic signed [WIDE-1:0] px_r, py_r, pz_r, qx_r, qy_r, qz_r, nx_r, ny_r, nz_r;
  logic signed [WIDE-1:0] det_r, un_r, vn_r, tn_r, acc_r, qv_r;
  logic [ACCW-1:0]        s_r;
  logic [WIDE-1:0]        len_r;
  logic [5:0]             step_r;
  logic [1:0]             nidx_r;
  logic                   pn_r, hit_r;
  logic signed [NORM_WIDTH-1:0] nrmx_r, nrmy_r, nrmz_r;
  logic                   out_valid_r;
  rti_out_t               out_word_r;

  // unit hookup
  rti_uop_t               uop;
  logic signed [WIDE-1:0] opa, opb;
  logic                   mul_start, mul_done;
  logic [ACCW-1:0]        prod;
  rti_ds_req_t            ds_req;
  logic [ACCW-1:0]        ds_num, ds_den;
  logic                   ds_done;
  logic [WIDE-1:0]        ds_res;

  logic                   accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign uop = rti_ucode(step_r);

  // operand select
  function automatic logic signed [WIDE-1:0] pick(input rti_opnd_t o,
      input logic signed [WIDE-1:0] dx, input logic signed [WIDE-1:0] dy,
      input logic signed [WIDE-1:0] dz);
    logic signed [WIDE-1:0] r;
    r = '0;
    case (o)
      OP_DX:  r = dx;
      OP_DY:  r = dy;
      OP_DZ:  r = dz;
      OP_E1X: r = e1x_r;
      OP_E1Y: r = e1y_r;
      OP_E1Z: r = e1z_r;
      OP_E2X: r = e2x_r;
      OP_E2Y: r = e2y_r;
      OP_E2Z: r = e2z_r;
      OP_TX:  r = tx_r;
      OP_TY:  r = ty_r;
      OP_TZ:  r = tz_r;
      OP_PX:  r = px_r;
      OP_PY:  r = py_r;
      OP_PZ:  r = pz_r;
      OP_QX:  r = qx_r;
      OP_QY:  r = qy_r;
      OP_QZ:  r = qz_r;
      OP_NX:  r = nx_r;
      OP_NY:  r = ny_r;
      OP_NZ:  r = nz_r;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(uop.a, WIDE'(dir_x_r), WIDE'(dir_y_r), WIDE'(dir_z_r));
    opb = pick(uop.b, WIDE'(dir_x_r), WIDE'(dir_y_r), WIDE'(dir_z_r));
  end

  assign mul_start = (state_r == S_ISSUE);

  rti_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (rti_mag(opa)),
    .b     (rti_mag(opb)),
    .done  (mul_done),
    .prod  (prod)
  );

  // rescale of the product: bias toward floor for negatives, shift, clamp
  logic [ACCW-1:0]        p_sh;
  logic [WIDE-1:0]        p_mag;
  always_comb begin
    p_sh  = (prod + (pn_r ? RND : '0)) >> FRAC_BITS;
    p_mag = (p_sh > ACCW'(WMAX)) ? WMAX : p_sh[WIDE-1:0];
  end

  // accumulate and saturate
  logic signed [WIDE-1:0] acc_base, acc_sum, acc_sat;
  always_comb begin
    acc_base = uop.first ? '0 : acc_r;
    acc_sum  = uop.neg ? (acc_base - qv_r) : (acc_base + qv_r);
    if (acc_sum > WMAX)       acc_sat = WMAX;
    else if (acc_sum < -WMAX) acc_sat = -WMAX;
    else                      acc_sat = acc_sum;
  end

  // range tests on folded numerators
  logic signed [WIDE-1:0] uv_sum;
  logic [ACCW-1:0]        t_num, t_lim;
  logic                   in_range;
  always_comb begin
    uv_sum   = un_r + vn_r;
    t_num    = ACCW'(tn_r[WIDE-2:0]) << FRAC_BITS;
    t_lim    = ACCW'(det_r[WIDE-2:0]) << 31;
    in_range = !un_r[WIDE-1] && (un_r <= det_r) && !vn_r[WIDE-1] &&
               (uv_sum <= det_r) && (tn_r > 0) && (t_num < t_lim);
  end

  // normal component under division
  logic signed [WIDE-1:0] ncomp;
  logic [NORM_WIDTH:0]    nq;
  logic signed [NORM_WIDTH-1:0] nunit;
  always_comb begin
    case (nidx_r)
      2'd0:    ncomp = nx_r;
      2'd1:    ncomp = ny_r;
      default: ncomp = nz_r;
    endcase
    nq = ds_res[NORM_WIDTH:0];
    if (ncomp[WIDE-1])              nunit = NORM_WIDTH'(0) - nq[NORM_WIDTH-1:0];
    else if (nq > 17'd32767)        nunit = 16'sd32767;
    else                            nunit = nq[NORM_WIDTH-1:0];
  end

  // divide / square root requests
  always_comb begin
    ds_req = '{start: 1'b0, sqrt_mode: 1'b0, count: 6'd0};
    ds_num = t_num;
    ds_den = ACCW'(det_r[WIDE-2:0]) << 30;
    case (state_r)
      S_TEST: begin
        ds_req.start = in_range;
        ds_req.count = 6'd31;
      end
      S_SQRT: begin
        ds_req.start     = 1'b1;
        ds_req.sqrt_mode = 1'b1;
        ds_req.count     = 6'd62;
        ds_num           = s_r;
      end
      S_NDIV: begin
        ds_req.start = 1'b1;
        ds_req.count = 6'd16;
        ds_num       = ACCW'(rti_mag(ncomp)) << 15;
        ds_den       = ACCW'(len_r) << 15;
      end
      default: ds_req.start = 1'b0;
    endcase
  end

  rti_divsqrt u_ds (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ds_req),
    .num    (ds_num),
    .den_sh (ds_den),
    .done   (ds_done),
    .res    (ds_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= 32'sd65536;
      maxd_r  <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORG_X:    org_x_r <= cfg_wdata;
        REG_ORG_Y:    org_y_r <= cfg_wdata;
        REG_ORG_Z:    org_z_r <= cfg_wdata;
        REG_DIR_X:    dir_x_r <= cfg_wdata;
        REG_DIR_Y:    dir_y_r <= cfg_wdata;
        REG_DIR_Z:    dir_z_r <= cfg_wdata;
        REG_MAX_DIST: maxd_r  <= cfg_wdata[DIST_WIDTH-1:0];
        default:      maxd_r  <= maxd_r;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      closest_r   <= '1;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      nidx_r      <= '0;
      hit_r       <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_word.new_ray) closest_r <= maxd_r;
            e1x_r  <= WIDE'(in_word.v2_x) - WIDE'(in_word.v1_x);
            e1y_r  <= WIDE'(in_word.v2_y) - WIDE'(in_word.v1_y);
            e1z_r  <= WIDE'(in_word.v2_z) - WIDE'(in_word.v1_z);
            e2x_r  <= WIDE'(in_word.v3_x) - WIDE'(in_word.v1_x);
            e2y_r  <= WIDE'(in_word.v3_y) - WIDE'(in_word.v1_y);
            e2z_r  <= WIDE'(in_word.v3_z) - WIDE'(in_word.v1_z);
            tx_r   <= WIDE'(org_x_r) - WIDE'(in_word.v1_x);
            ty_r   <= WIDE'(org_y_r) - WIDE'(in_word.v1_y);
            tz_r   <= WIDE'(org_z_r) - WIDE'(in_word.v1_z);
            step_r <= '0;
            hit_r  <= 1'b0;
            nrmx_r <= '0;
            nrmy_r <= '0;
            nrmz_r <= '0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          pn_r    <= opa[WIDE-1] ^ opb[WIDE-1];
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) state_r <= S_POST;
        end
        S_POST: begin
          qv_r    <= pn_r ? (WIDE'(0) - p_mag) : p_mag;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (uop.sq) begin
            s_r <= (uop.first ? '0 : s_r) + prod;
          end else if (uop.last) begin
            case (uop.dst)
              DST_PX:  px_r  <= acc_sat;
              DST_PY:  py_r  <= acc_sat;
              DST_PZ:  pz_r  <= acc_sat;
              DST_QX:  qx_r  <= acc_sat;
              DST_QY:  qy_r  <= acc_sat;
              DST_QZ:  qz_r  <= acc_sat;
              DST_NX:  nx_r  <= acc_sat;
              DST_NY:  ny_r  <= acc_sat;
              DST_NZ:  nz_r  <= acc_sat;
              DST_DET: det_r <= acc_sat;
              DST_UN:  un_r  <= acc_sat;
              DST_VN:  vn_r  <= acc_sat;
              DST_TN:  tn_r  <= acc_sat;
              default: acc_r <= acc_sum;
            endcase
          end else begin
            acc_r <= acc_sum;
          end
          step_r <= step_r + 6'd1;
          if (step_r == STEP_TEST_END)  state_r <= S_FOLD;
          else if (step_r == STEP_LAST) state_r <= S_SQRT;
          else                          state_r <= S_ISSUE;
        end
        // reject small det, otherwise make det positive
        S_FOLD: begin
          if (rti_mag(det_r) < EPS) begin
            state_r <= S_DONE;
          end else begin
            if (det_r[WIDE-1]) begin
              det_r <= -det_r;
              un_r  <= -un_r;
              vn_r  <= -vn_r;
              tn_r  <= -tn_r;
            end
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          state_r <= in_range ? S_TWAIT : S_DONE;
        end
        // quantized t against the closest distance so far
        S_TWAIT: begin
          if (ds_done) begin
            if ((ds_res[DIST_WIDTH-1:0] != '0) && (ds_res[DIST_WIDTH-1:0] <= closest_r)) begin
              hit_r     <= 1'b1;
              closest_r <= ds_res[DIST_WIDTH-1:0];
              step_r    <= STEP_NRM;
              state_r   <= S_ISSUE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SQRT: state_r <= S_SQWAIT;
        S_SQWAIT: begin
          if (ds_done) begin
            len_r   <= ds_res;
            nidx_r  <= '0;
            state_r <= (ds_res == '0) ? S_DONE : S_NDIV;
          end
        end
        S_NDIV: state_r <= S_NWAIT;
        S_NWAIT: begin
          if (ds_done) begin
            case (nidx_r)
              2'd0:    nrmx_r <= nunit;
              2'd1:    nrmy_r <= nunit;
              default: nrmz_r <= nunit;
            endcase
            nidx_r  <= nidx_r + 2'd1;
            state_r <= (nidx_r == 2'd2) ? S_DONE : S_NDIV;
          end
        end
        // hand the word to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{hit: hit_r, distance: closest_r, normal_x: nrmx_r,
                             normal_y: nrmy_r, normal_z: nrmz_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.hit |-> out_word_r.normal_x == '0 &&
      out_word_r.normal_y == '0 && out_word_r.normal_z == '0)
    else $error("miss word carries a normal");

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.hit |-> out_word_r.distance != '0)
    else $error("hit with zero distance");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("sequencer did not start");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MWAIT)
    else $error("product finished outside its wait state");

endmodule

[tb/rti_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Watches the triangle and result channels of ray_triangle_intersect and
// keeps its own copy of the ray registers and the closest distance. For each
// accepted triangle word it works out the expected result in exact wide
// integer arithmetic. Each result word is then compared field by field with
// the oldest expected word.
// ----------------------------------------------------------------------------
module rti_checker
  import rti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rti_in_t           in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rti_out_t          out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                hit_count
);

  localparam int       FB      = FRAC_BITS_DEF;
  localparam longint   EPSILON = ((64'd1 << FB) + 5000) / 10000;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  // shadow of the ray registers and the running closest distance
  coord_t                org_x, org_y, org_z;
  coord_t                dir_x, dir_y, dir_z;
  logic [DIST_WIDTH-1:0] dist_limit;
  logic [DIST_WIDTH-1:0] closest;

  rti_out_t expected_results[$];

  function automatic logic [63:0] abs64(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // signed fixed-point product: floor after rescale, then clamp
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] p;
    logic         neg;
    neg = (a < 0) != (b < 0);
    p = 128'(abs64(a)) * 128'(abs64(b));
    if (neg) p = p + ((128'd1 << FB) - 1);
    p = p >> FB;
    if (p > 128'(WMAX)) return neg ? -WMAX : WMAX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp(input longint x);
    if (x > WMAX) return WMAX;
    if (x < -WMAX) return -WMAX;
    return x;
  endfunction

  function automatic vec3_t vdiff(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t vcross(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = clamp(fx_mul(a.y, b.z) - fx_mul(a.z, b.y));
    r.y = clamp(fx_mul(a.z, b.x) - fx_mul(a.x, b.z));
    r.z = clamp(fx_mul(a.x, b.y) - fx_mul(a.y, b.x));
    return r;
  endfunction

  function automatic longint vdot(input vec3_t a, input vec3_t b);
    return clamp(fx_mul(a.x, b.x) + fx_mul(a.y, b.y) + fx_mul(a.z, b.z));
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 61; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    return r;
  endfunction

  // one normal component in Q1.15; +1.0 clamps, -1.0 stays -32768
  function automatic logic signed [NORM_WIDTH-1:0] unit_comp(input longint n,
                                                            input logic [63:0] len);
    logic [127:0] m;
    if (len == 0) return '0;
    m = (128'(abs64(n)) << 15) / 128'(len);
    if (n < 0) return NORM_WIDTH'(-m[63:0]);
    return (m > 32767) ? 16'sd32767 : NORM_WIDTH'(m);
  endfunction

  // expected result of one triangle test; updates the closest distance
  function automatic rti_out_t nearest_hit_predict(input rti_in_t w);
    vec3_t        v1, v2, v3, org, dir, e1, e2, p, tv, q, n;
    longint       det, un, vn, tn;
    logic [127:0] num, quo, sq;
    logic [63:0]  len;
    rti_out_t     r;
    r = '0;
    if (w.new_ray) closest = dist_limit;
    v1 = '{w.v1_x, w.v1_y, w.v1_z};
    v2 = '{w.v2_x, w.v2_y, w.v2_z};
    v3 = '{w.v3_x, w.v3_y, w.v3_z};
    org = '{org_x, org_y, org_z};
    dir = '{dir_x, dir_y, dir_z};
    e1 = vdiff(v2, v1);
    e2 = vdiff(v3, v1);
    p = vcross(dir, e2);
    det = vdot(e1, p);
    tv = vdiff(org, v1);
    un = vdot(tv, p);
    q = vcross(tv, e1);
    vn = vdot(dir, q);
    tn = vdot(e2, q);
    if (abs64(det) >= EPSILON) begin
      if (det < 0) begin
        det = -det;
        un = -un;
        vn = -vn;
        tn = -tn;
      end
      if (un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn > 0) begin
        num = 128'(tn) << FB;
        if (num < (128'(det) << 31)) begin
          quo = num / 128'(det);
          if (quo != 0 && quo <= 128'(closest)) begin
            r.hit = 1'b1;
            closest = DIST_WIDTH'(quo);
          end
        end
      end
    end
    if (r.hit) begin
      n = vcross(e1, e2);
      sq = 128'(abs64(n.x)) * 128'(abs64(n.x)) + 128'(abs64(n.y)) * 128'(abs64(n.y))
         + 128'(abs64(n.z)) * 128'(abs64(n.z));
      len = floor_sqrt(sq);
      r.normal_x = unit_comp(n.x, len);
      r.normal_y = unit_comp(n.y, len);
      r.normal_z = unit_comp(n.z, len);
    end
    r.distance = closest;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= 32'sd65536;
      dist_limit <= '1;
      closest = '1;
      fail_count <= 0;
      hit_count <= 0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (rti_reg_t'(cfg_addr))
          REG_ORG_X:    org_x <= cfg_wdata;
          REG_ORG_Y:    org_y <= cfg_wdata;
          REG_ORG_Z:    org_z <= cfg_wdata;
          REG_DIR_X:    dir_x <= cfg_wdata;
          REG_DIR_Y:    dir_y <= cfg_wdata;
          REG_DIR_Z:    dir_z <= cfg_wdata;
          REG_MAX_DIST: dist_limit <= cfg_wdata[DIST_WIDTH-1:0];
          default: ;
        endcase
      end
      // triangle word accepted
      if (in_valid && !in_stall)
        expected_results = {expected_results, nearest_hit_predict(in_word)};
      // result word accepted
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: %p", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          rti_out_t e;
          e = expected_results.pop_front();
          if (out_word.hit) hit_count <= hit_count + 1;
          if (e !== out_word) begin
            fail_count <= fail_count + 1;
            if (e.hit !== out_word.hit)
              $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_word.hit);
            if (e.distance !== out_word.distance)
              $display("%0t: distance expected %0h actual %0h", $time, e.distance,
                       out_word.distance);
            if (e.normal_x !== out_word.normal_x)
              $display("%0t: normal_x expected %0d actual %0d", $time, e.normal_x,
                       out_word.normal_x);
            if (e.normal_y !== out_word.normal_y)
              $display("%0t: normal_y expected %0d actual %0d", $time, e.normal_y,
                       out_word.normal_y);
            if (e.normal_z !== out_word.normal_z)
              $display("%0t: normal_z expected %0d actual %0d", $time, e.normal_z,
                       out_word.normal_z);
          end
        end
      end
    end
  end

endmodule

[tb/tb_ray_triangle_intersect.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect
// Drives ray_triangle_intersect through several ray settings: the reset ray,
// a steep ray for tiny triangles, register extremes and random rays. Most
// triangles are built around a point on the ray so that hits are common; the
// rest are full-range noise or broken triangles. Both channels idle at random
// and the result side holds off once for a long stretch. rti_checker does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;
  import rti_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PER_RAY = 48;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rti_in_t           in_word;
  logic              out_valid;
  logic              out_stall;
  rti_out_t          out_word;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                hit_count;
  int                cycles = 0;
  int                words_sent;

  // ray as last written, used to aim triangles
  longint ray_o[3];
  longint ray_d[3];

  ray_triangle_intersect dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall,
    .out_word, .cfg_we, .cfg_addr, .cfg_wdata
  );

  rti_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall,
    .out_word, .cfg_we, .cfg_addr, .cfg_wdata, .fail_count, .pending, .hit_count
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // cycle count and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, a quiet window and one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (cycles == 30000) hold = 4000;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (cycles > 60000 && cycles < 90000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 27);
      end
    end
  end

  task automatic write_reg(input rti_reg_t idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_ray(input longint o[3], input longint d[3],
                         input logic [CFG_DW-1:0] lim);
    write_reg(REG_ORG_X, o[0][31:0]);
    write_reg(REG_ORG_Y, o[1][31:0]);
    write_reg(REG_ORG_Z, o[2][31:0]);
    write_reg(REG_DIR_X, d[0][31:0]);
    write_reg(REG_DIR_Y, d[1][31:0]);
    write_reg(REG_DIR_Z, d[2][31:0]);
    write_reg(REG_MAX_DIST, lim);
    cfg_we <= 1'b0;
    ray_o = o;
    ray_d = d;
    @(posedge clk);
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // offer one word and hold it until accepted, with a random gap before it except for words 150 to 199
  task automatic send(input rti_in_t w);
    bit quiet;
    quiet = (words_sent >= 150 && words_sent < 200);
    if (!quiet) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  function automatic rti_in_t tri_word(input bit nr, input longint a[3],
                                       input longint b[3], input longint c[3]);
    rti_in_t w;
    w.new_ray = nr;
    w.v1_x = a[0][31:0]; w.v1_y = a[1][31:0]; w.v1_z = a[2][31:0];
    w.v2_x = b[0][31:0]; w.v2_y = b[1][31:0]; w.v2_z = b[2][31:0];
    w.v3_x = c[0][31:0]; w.v3_y = c[1][31:0]; w.v3_z = c[2][31:0];
    return w;
  endfunction

  function automatic longint srand(input int bits);
    return longint'($urandom_range((1 << bits) - 1)) - (longint'(1) << (bits - 1));
  endfunction

  // triangle with centroid on the ray at integer step k; sometimes broken
  function automatic rti_in_t aimed_tri(input bit nr, input int k);
    longint h[3], a[3], b[3], c[3], off_a[3], off_b[3];
    int spread;
    spread = $urandom_range(20, 10);
    for (int i = 0; i < 3; i++) begin
      h[i] = ray_o[i] + k * ray_d[i];
      off_a[i] = srand(spread);
      off_b[i] = srand(spread);
      a[i] = h[i] + off_a[i];
      b[i] = h[i] + off_b[i];
      c[i] = h[i] - off_a[i] - off_b[i];
    end
    case ($urandom_range(9))
      0: b = a;                                          // collapsed edge
      1: c[$urandom_range(2)] += srand(24);              // pushed off the ray
      default: ;
    endcase
    return tri_word(nr, a, b, c);
  endfunction

  function automatic rti_in_t noise_tri();
    rti_in_t w;
    w.new_ray = $urandom_range(1);
    w.v1_x = $urandom; w.v1_y = $urandom; w.v1_z = $urandom;
    w.v2_x = $urandom; w.v2_y = $urandom; w.v2_z = $urandom;
    w.v3_x = $urandom; w.v3_y = $urandom; w.v3_z = $urandom;
    return w;
  endfunction

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80)
        send(aimed_tri($urandom_range(3) == 0, $urandom_range(40) - 4));
      else
        send(noise_tri());
    end
  endtask

  initial begin
    longint o[3], d[3];
    longint f;
    f = 65536;
    words_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, 65536};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset ray, axis-aligned triangles, windings, behind, extremes
    send(tri_word(1'b0, '{-f, -f, 5*f}, '{f, -f, 5*f}, '{0, f, 5*f}));
    send(tri_word(1'b0, '{-f, -f, 8*f}, '{0, f, 8*f}, '{f, -f, 8*f}));
    send(tri_word(1'b0, '{-f, -f, 2*f}, '{0, f, 2*f}, '{f, -f, 2*f}));
    send(tri_word(1'b0, '{-f, -f, 2*f}, '{f, -f, 2*f}, '{0, f, 2*f}));
    send(tri_word(1'b1, '{-f, -f, -5*f}, '{f, -f, -5*f}, '{0, f, -5*f}));
    send(tri_word(1'b1, '{-f, -f, 0}, '{f, -f, 0}, '{0, f, 0}));
    send(tri_word(1'b1, '{-f, 0, 0}, '{f, 0, 3*f}, '{0, f, 2*f}));
    send(tri_word(1'b1, '{f, f, 4*f}, '{2*f, f, 4*f}, '{f, 2*f, 4*f}));
    send('0);
    send(tri_word(1'b1, '{-f, -f, 3*f}, '{f, f, 3*f}, '{2*f, 2*f, 3*f}));
    send({1'b1, {9{32'h7FFF_FFFF}}});
    send({1'b1, {9{32'h8000_0000}}});
    send({1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send(tri_word(1'b1, '{-7, -7, f}, '{7, -7, f}, '{0, 7, f}));
    random_items(RAND_PER_RAY);
    drain();

    // steep ray against a tiny triangle whose normal rounds to zero
    set_ray('{60, 60, -f}, '{0, 0, 64'h7FFF_FFFF}, 32'h7FFF_FFFF);
    send(tri_word(1'b1, '{0, 0, 0}, '{255, 0, 0}, '{0, 255, 0}));
    send(tri_word(1'b1, '{0, 0, 0}, '{0, 255, 0}, '{255, 0, 0}));
    random_items(RAND_PER_RAY);
    drain();

    // register extremes
    set_ray('{64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF},
            '{64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF}, 32'h7FFF_FFFF);
    random_items(RAND_PER_RAY / 2);
    drain();
    set_ray('{-64'h8000_0000, -64'h8000_0000, -64'h8000_0000},
            '{-64'h8000_0000, -64'h8000_0000, -64'h8000_0000}, 32'h0);
    random_items(RAND_PER_RAY / 2);
    drain();

    // random rays with modest sizes
    for (int r = 0; r < 5; r++) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = srand(22);
        d[i] = srand(18);
      end
      set_ray(o, d, (r == 0) ? 32'd1 : ($urandom >> $urandom_range(12)));
      random_items(RAND_PER_RAY);
      drain();
    end

    $display("Sent %0d triangle words over 9 ray settings; %0d hits returned.",
             words_sent, hit_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
